/* hw/rtl/ifhc_pkg.sv */
// ----------------------------------------------------------------------------
// Image frame header checker package
// Shared constants, status codes and transaction types.
// ----------------------------------------------------------------------------
package ifhc_pkg;

   // Header layout
   localparam int HEADER_LEN  = 32;
   localparam int INDEX_W     = $clog2(HEADER_LEN);
   // Bytes 24..31 are never reported, so only the first 24 are kept
   localparam int STORE_LEN   = 24;

   localparam int POS_MAGIC     = 0;
   localparam int POS_VERSION   = 4;
   localparam int POS_FORMAT    = 5;
   localparam int POS_FLAGS     = 6;
   localparam int POS_FRAME_NUM = 8;
   localparam int POS_WIDTH     = 12;
   localparam int POS_HEIGHT    = 14;
   localparam int POS_PAYLOAD   = 16;
   localparam int POS_CHECKSUM  = 20;

   localparam logic [7:0] MAGIC_0 = 8'h49;  // 'I'
   localparam logic [7:0] MAGIC_1 = 8'h52;  // 'R'
   localparam logic [7:0] MAGIC_2 = 8'h44;  // 'D'
   localparam logic [7:0] MAGIC_3 = 8'h54;  // 'T'

   // Status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MAGIC     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_VERSION   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FORMAT    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_SIZE = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 3'd6;

   // Configuration registers
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_VERSION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_FORMAT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PAYLOAD      = 2'd2;

   localparam logic [7:0]  RESET_EXPECTED_VERSION = 8'd1;
   localparam logic [7:0]  RESET_EXPECTED_FORMAT  = 8'd1;
   localparam logic [31:0] RESET_MAX_PAYLOAD      = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0] header_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [15:0]         flags;
      logic [31:0]         frame_number;
      logic [15:0]         width;
      logic [15:0]         height;
      logic [31:0]         payload_len;
      logic [31:0]         checksum_word;
      logic [7:0]          version_seen;
      logic [7:0]          format_seen;
   } rsp_type;

endpackage

/* hw/rtl/image_frame_header_checker_unit.sv */
// ----------------------------------------------------------------------------
// Image frame header checker unit
// Collects a 32-byte little-endian frame header and reports its fields
// together with a validation status once the last byte has arrived.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | req_type: header byte, restart
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_type: status and fields
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// One byte transaction is taken every cycle. A result transaction is presented
// once the transaction carrying the last header byte has been accepted into
// the input register and has then advanced from it into the result register.
// The width*height product is registered when byte 16 is processed, so the
// final check is a compare against a stored product, not a multiply.
// Reset clears the byte position and pipeline valids and presets the configuration.
// The input stalls only when the last byte waits behind an untaken result.
//
module image_frame_header_checker_unit
   import ifhc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,

   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers
   logic [7:0]  expected_version_ff;
   logic [7:0]  expected_format_ff;
   logic [31:0] max_payload_ff;

   // Input register
   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;

   // Header position and stored bytes
   logic [INDEX_W-1:0] byte_index_ff, byte_index_in;
   logic [7:0]         header_store_ff [STORE_LEN];
   logic [31:0]        product_ff;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic               advance;
   logic               is_last;
   logic [INDEX_W-1:0] pos;
   logic [15:0]        hdr_width, hdr_height;
   logic [31:0]        hdr_payload;

   // ------------------------------------------------------------------
   // Configuration writes; indexes beyond the list are dropped
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= RESET_EXPECTED_VERSION;
         expected_format_ff  <= RESET_EXPECTED_FORMAT;
         max_payload_ff      <= RESET_MAX_PAYLOAD;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_EXPECTED_VERSION: expected_version_ff <= csr_wdata[7:0];
            CSR_EXPECTED_FORMAT:  expected_format_ff  <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD:      max_payload_ff      <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Position of the byte in the input register
   // ------------------------------------------------------------------
   assign pos     = in_data_ff.restart ? '0 : byte_index_ff;
   assign is_last = (pos == INDEX_W'(HEADER_LEN - 1));

   // Advance the byte unless it is the last one and the result slot is busy
   assign advance = in_valid_ff && (!is_last || !rsp_valid_ff || rsp_ready);

   // Accept a new byte whenever the input register drains this cycle
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   assign byte_index_in = advance ? (is_last ? '0 : pos + INDEX_W'(1)) : byte_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         byte_index_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         byte_index_ff <= byte_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // Header store: write the advancing byte at its position
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_LEN; i++) begin
         if (advance && (pos == INDEX_W'(i))) begin
            header_store_ff[i] <= in_data_ff.header_byte;
         end
      end
   end

   assign hdr_width   = {header_store_ff[POS_WIDTH + 1], header_store_ff[POS_WIDTH]};
   assign hdr_height  = {header_store_ff[POS_HEIGHT + 1], header_store_ff[POS_HEIGHT]};
   assign hdr_payload = {header_store_ff[POS_PAYLOAD + 3], header_store_ff[POS_PAYLOAD + 2],
                         header_store_ff[POS_PAYLOAD + 1], header_store_ff[POS_PAYLOAD]};

   // Width and height are complete once byte 15 is stored; latch the
   // product while byte 16 passes so the last byte only compares
   always_ff @(posedge clock) begin
      if (advance && (pos == INDEX_W'(POS_PAYLOAD))) begin
         product_ff <= 32'(hdr_width) * 32'(hdr_height);
      end
   end

   // ------------------------------------------------------------------
   // Decode fields and pick the first failing check
   // ------------------------------------------------------------------
   always_comb begin
      rsp_data_in.flags         = {header_store_ff[POS_FLAGS + 1], header_store_ff[POS_FLAGS]};
      rsp_data_in.frame_number  = {header_store_ff[POS_FRAME_NUM + 3],
                                   header_store_ff[POS_FRAME_NUM + 2],
                                   header_store_ff[POS_FRAME_NUM + 1],
                                   header_store_ff[POS_FRAME_NUM]};
      rsp_data_in.width         = hdr_width;
      rsp_data_in.height        = hdr_height;
      rsp_data_in.payload_len   = hdr_payload;
      rsp_data_in.checksum_word = {header_store_ff[POS_CHECKSUM + 3],
                                   header_store_ff[POS_CHECKSUM + 2],
                                   header_store_ff[POS_CHECKSUM + 1],
                                   header_store_ff[POS_CHECKSUM]};
      rsp_data_in.version_seen  = header_store_ff[POS_VERSION];
      rsp_data_in.format_seen   = header_store_ff[POS_FORMAT];

      priority if (header_store_ff[POS_MAGIC]     != MAGIC_0 ||
                   header_store_ff[POS_MAGIC + 1] != MAGIC_1 ||
                   header_store_ff[POS_MAGIC + 2] != MAGIC_2 ||
                   header_store_ff[POS_MAGIC + 3] != MAGIC_3) begin
         rsp_data_in.status = STATUS_MAGIC;
      end else if (header_store_ff[POS_VERSION] != expected_version_ff) begin
         rsp_data_in.status = STATUS_VERSION;
      end else if (header_store_ff[POS_FORMAT] != expected_format_ff) begin
         rsp_data_in.status = STATUS_FORMAT;
      end else if (hdr_width == '0 || hdr_height == '0) begin
         rsp_data_in.status = STATUS_ZERO_SIZE;
      end else if (hdr_payload != product_ff) begin
         rsp_data_in.status = STATUS_MISMATCH;
      end else if (hdr_payload > max_payload_ff) begin
         rsp_data_in.status = STATUS_TOO_LARGE;
      end else begin
         rsp_data_in.status = STATUS_OK;
      end
   end

   // ------------------------------------------------------------------
   // Result register: load on the last byte, hold until taken
   // ------------------------------------------------------------------
   assign rsp_valid_in = (advance && is_last) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // The last byte always returns the position to zero
   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (advance && is_last) |=> (byte_index_ff == '0))
      else $error("byte position did not wrap after last byte");

   // A restart byte lands at position zero, so the next one is position one
   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.restart) |=> (byte_index_ff == INDEX_W'(1)))
      else $error("restart did not realign byte position");

   // The input never stalls while the result slot is empty
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !rsp_valid_ff) |-> advance)
      else $error("byte held with an empty result register");

   // An OK status implies a consistent and permitted payload size
   a_ok_consistent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == STATUS_OK) |->
         (rsp_data_ff.payload_len ==
             32'(rsp_data_ff.width) * 32'(rsp_data_ff.height) &&
          rsp_data_ff.payload_len <= max_payload_ff))
      else $error("OK status with inconsistent payload size");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Image frame header checker testbench
// Streams header bytes into the unit and decodes every completed header with
// its own byte-level model. Each reported header is compared field by field,
// status included, against the oldest decoded header still due. Directed
// frames cover every status and the register extremes, then random frames
// run under three handshake pacing mixes and several register settings.
// ----------------------------------------------------------------------------
module testbench;
   import ifhc_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES = 4;     // a result trails its last byte through the input and result registers
   localparam int RANDOM_BYTES  = 170;   // per random phase
   localparam int RANDOM_FRAMES = 5;     // per random phase, at least
   localparam logic [31:0] MAGIC_WORD = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_type                req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = CSR_EXPECTED_VERSION;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // Decoder model: byte store, write position and register copies
   logic [7:0]         model_bytes [HEADER_LEN];
   logic [INDEX_W-1:0] model_pos       = '0;
   logic [7:0]         cfg_version     = RESET_EXPECTED_VERSION;
   logic [7:0]         cfg_format      = RESET_EXPECTED_FORMAT;
   logic [31:0]        cfg_max_payload = RESET_MAX_PAYLOAD;
   rsp_type            decoded_headers_due [$];

   int error_count        = 0;
   int stall_cycles       = 0;
   int sender_gap_pct     = 0;
   int receiver_stall_pct = 0;
   int bytes_sent         = 0;

   image_frame_header_checker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // Decoder model
   // ------------------------------------------------------------------------

   // Assemble a little-endian field from the stored header bytes
   function automatic logic [31:0] header_field(input int pos, input int nbytes);
      logic [31:0] value;
      value = '0;
      for (int i = nbytes - 1; i >= 0; i--) value = {value[23:0], model_bytes[pos + i]};
      return value;
   endfunction

   // Store one accepted byte; on the last byte decode the header, rank the
   // checks in their fixed order and queue the header as due
   task automatic decode_header_byte(input req_type item);
      rsp_type     hdr;
      logic [31:0] area;
      if (item.restart) model_pos = '0;
      model_bytes[model_pos] = item.header_byte;
      if (model_pos != INDEX_W'(HEADER_LEN - 1)) begin
         model_pos = model_pos + INDEX_W'(1);
         return;
      end
      model_pos         = '0;
      hdr.flags         = 16'(header_field(POS_FLAGS, 2));
      hdr.frame_number  = header_field(POS_FRAME_NUM, 4);
      hdr.width         = 16'(header_field(POS_WIDTH, 2));
      hdr.height        = 16'(header_field(POS_HEIGHT, 2));
      hdr.payload_len   = header_field(POS_PAYLOAD, 4);
      hdr.checksum_word = header_field(POS_CHECKSUM, 4);
      hdr.version_seen  = model_bytes[POS_VERSION];
      hdr.format_seen   = model_bytes[POS_FORMAT];
      area = 32'(hdr.width) * 32'(hdr.height);
      if (header_field(POS_MAGIC, 4) != MAGIC_WORD)        hdr.status = STATUS_MAGIC;
      else if (hdr.version_seen != cfg_version)            hdr.status = STATUS_VERSION;
      else if (hdr.format_seen != cfg_format)              hdr.status = STATUS_FORMAT;
      else if (hdr.width == '0 || hdr.height == '0)        hdr.status = STATUS_ZERO_SIZE;
      else if (hdr.payload_len != area)                    hdr.status = STATUS_MISMATCH;
      else if (hdr.payload_len > cfg_max_payload)          hdr.status = STATUS_TOO_LARGE;
      else                                                 hdr.status = STATUS_OK;
      decoded_headers_due.push_back(hdr);
   endtask

   // Pack header fields in wire order, byte 0 in the low bits; the trailing
   // eight bytes are neither stored by the unit nor reported
   function automatic logic [8*HEADER_LEN-1:0] header_image(
      input logic [31:0] magic, input logic [7:0] version, input logic [7:0] format,
      input logic [15:0] width, input logic [15:0] height, input logic [31:0] payload);
      return {32'($urandom), 32'($urandom), 32'($urandom), payload, height, width,
              32'($urandom), 16'($urandom), format, version, magic};
   endfunction

   // ------------------------------------------------------------------------
   // Reporting and result checking
   // ------------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
   endtask

   // Check every result transaction against the oldest header still due
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_headers_due.size() == 0) begin
            report_error("result with no completed header pending");
         end else begin
            want = decoded_headers_due.pop_front();
            compare_field("status", 32'(rsp_data.status), 32'(want.status));
            compare_field("flags", 32'(rsp_data.flags), 32'(want.flags));
            compare_field("frame_number", rsp_data.frame_number, want.frame_number);
            compare_field("width", 32'(rsp_data.width), 32'(want.width));
            compare_field("height", 32'(rsp_data.height), 32'(want.height));
            compare_field("payload_len", rsp_data.payload_len, want.payload_len);
            compare_field("checksum_word", rsp_data.checksum_word, want.checksum_word);
            compare_field("version_seen", 32'(rsp_data.version_seen),
                          32'(want.version_seen));
            compare_field("format_seen", 32'(rsp_data.format_seen),
                          32'(want.format_seen));
         end
      end
   end

   // Stall the result side at random; hold ready low through reset
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // End the run once nothing has moved on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Present one byte transaction and hold it until the unit takes it. Valid
   // stays high afterwards so back-to-back bytes follow without a gap.
   task automatic send_byte(input logic [7:0] value, input logic restart);
      req_type item;
      item.header_byte = value;
      item.restart     = restart;
      if ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_gap_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      decode_header_byte(item);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [8*HEADER_LEN-1:0] image, input logic restart_first);
      for (int i = 0; i < HEADER_LEN; i++) send_byte(image[8*i +: 8], restart_first && i == 0);
   endtask

   // Drop valid and hold off until every decoded header has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (decoded_headers_due.size() != 0);
   endtask

   // Complete any partial header, drain the results, then let the pipeline
   // empty so the registers can be rewritten safely
   task automatic settle_block();
      while (model_pos != '0) send_byte(8'($urandom), 1'b0);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all three registers; junk in the upper bits of the 8-bit ones
   // must be ignored
   task automatic apply_settings(input logic [7:0] version, input logic [7:0] format,
                                 input logic [31:0] max_payload);
      settle_block();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_EXPECTED_VERSION;
      csr_wdata    <= {24'($urandom), version};
      @(posedge clock);
      csr_index    <= CSR_EXPECTED_FORMAT;
      csr_wdata    <= {24'($urandom), format};
      @(posedge clock);
      csr_index    <= CSR_MAX_PAYLOAD;
      csr_wdata    <= max_payload;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_version     = version;
      cfg_format      = format;
      cfg_max_payload = max_payload;
   endtask

   // Mostly well-formed headers with random content; some carry a broken
   // field or follow an abandoned partial header
   task automatic send_random_frame();
      logic [31:0] magic;
      logic [31:0] area;
      logic [31:0] payload;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  version;
      logic [7:0]  format;
      logic        restart_first;
      int          pick;
      int          k;
      magic = MAGIC_WORD;
      if ($urandom_range(99) < 10) begin
         k = $urandom_range(3);
         magic[8*k +: 8] = magic[8*k +: 8] ^ 8'($urandom_range(1, 255));
      end
      version = ($urandom_range(99) < 88) ? cfg_version : 8'($urandom);
      format  = ($urandom_range(99) < 88) ? cfg_format : 8'($urandom);
      width   = ($urandom_range(99) < 20) ? 16'($urandom) : 16'($urandom_range(1, 255));
      height  = ($urandom_range(99) < 20) ? 16'($urandom) : 16'($urandom_range(1, 255));
      pick = $urandom_range(99);
      if (pick < 4) width = '0;
      else if (pick < 8) height = '0;
      else if (pick < 10) {width, height} = '0;
      area = 32'(width) * 32'(height);
      pick = $urandom_range(99);
      if (pick < 76) payload = area;
      else if (pick < 88) payload = pick[0] ? area + 32'd1 : area - 32'd1;
      else payload = $urandom;
      // Abandon a partial header now and then, restarts scattered inside it
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, HEADER_LEN - 1))
            send_byte(8'($urandom), $urandom_range(3) == 0);
         restart_first = 1'b1;
      end else begin
         restart_first = 1'($urandom_range(1));
      end
      send_frame(header_image(magic, version, format, width, height, payload), restart_first);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Headers for every status except too-large under the reset register
   // values, with checks that fail together to show which one wins
   task automatic test_status_codes();
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd640, 16'd480,
                              32'd307200), 1'b0);
      // flags, frame number, width, height and checksum at their maximum, still a clean header
      send_frame({64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFE_0001, 16'hFFFF,
                  16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, cfg_format, cfg_version,
                  MAGIC_WORD}, 1'b0);
      // all-zero header fails the magic
      send_frame('0, 1'b1);
      send_frame(header_image(MAGIC_WORD ^ 32'h0000_0001, cfg_version, cfg_format,
                              16'd4, 16'd4, 32'd16), 1'b0);
      send_frame(header_image(MAGIC_WORD ^ 32'h8000_0000, 8'h00, cfg_format,
                              16'd4, 16'd4, 32'd16), 1'b0);
      send_frame(header_image(MAGIC_WORD, 8'h00, 8'h80, 16'd4, 16'd4, 32'd16), 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, 8'hFF, 16'd0, 16'd4, 32'd16), 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd0, 16'd5, 32'd0),
                 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd7, 16'd0,
                              32'd123), 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd3, 16'd5, 32'd16),
                 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd3, 16'd5, 32'd14),
                 1'b0);
   endtask

   // Restart in the middle of a header, right before its last byte, and on
   // several bytes in a row
   task automatic test_restart_mid_header();
      logic [8*HEADER_LEN-1:0] image;
      repeat (13) send_byte(8'($urandom), 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd2, 16'd9, 32'd18),
                 1'b1);
      image = header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd5, 16'd5, 32'd25);
      for (int i = 0; i < HEADER_LEN - 1; i++) send_byte(image[8*i +: 8], 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd6, 16'd6,
                              32'd36), 1'b1);
      // consecutive restarts leave the next header shifted by one byte
      repeat (3) send_byte(8'($urandom), 1'b1);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd1, 16'd1, 32'd1),
                 1'b0);
      send_frame(header_image(MAGIC_WORD, cfg_version, cfg_format, 16'd8, 16'd8, 32'd64),
                 1'b1);
   endtask

   // Register extremes and the payload limit boundary
   task automatic test_register_extremes();
      apply_settings(8'h00, 8'hFF, 32'd0);
      send_frame(header_image(MAGIC_WORD, 8'h00, 8'hFF, 16'd1, 16'd1, 32'd1), 1'b1);
      send_frame(header_image(MAGIC_WORD, 8'h00, 8'hFF, 16'd0, 16'd0, 32'd0), 1'b0);
      apply_settings(8'hFF, 8'h00, 32'd307200);
      send_frame(header_image(MAGIC_WORD, 8'hFF, 8'h00, 16'd640, 16'd480, 32'd307200),
                 1'b0);
      send_frame(header_image(MAGIC_WORD, 8'hFF, 8'h00, 16'd641, 16'd480, 32'd307680),
                 1'b0);
      apply_settings(8'hA5, 8'h5A, 32'd307199);
      send_frame(header_image(MAGIC_WORD, 8'hA5, 8'h5A, 16'd640, 16'd480, 32'd307200),
                 1'b0);
      send_frame(header_image(MAGIC_WORD, 8'h01, 8'h5A, 16'd640, 16'd480, 32'd307200),
                 1'b0);
   endtask

   // Random frames under one pacing mix and one register setting; hold off
   // before the fourth frame, and now and then at random, until the unit has returned every header
   task automatic test_random_frames(input int gap_pct, input int stall_pct,
                                     input logic [7:0] version, input logic [7:0] format,
                                     input logic [31:0] max_payload);
      int frames;
      int first_byte;
      apply_settings(version, format, max_payload);
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      frames     = 0;
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
         if (frames == 3 || $urandom_range(99) < 4) wait_for_results();
         send_random_frame();
         frames++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      sender_gap_pct     = 33;
      receiver_stall_pct = 57;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_status_codes();
      test_restart_mid_header();
      test_register_extremes();

      test_random_frames(33, 57, 8'($urandom), 8'($urandom), $urandom_range(70000));
      test_random_frames(57, 33, 8'hFF, 8'h00, 32'hFFFF_FFFF);
      test_random_frames(0, 0, 8'($urandom), 8'($urandom), $urandom);

      // Drain, then watch a little longer for stray results
      settle_block();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/ifhc_pkg.sv
hw/rtl/image_frame_header_checker_unit.sv
bench/testbench.sv
